// File: src/assert_macros.svh
// Assertion macros shared by the negative cache RTL.
// Pulled in by every file that checks its own logic; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/einc_pkg.sv
// Types and constants of the epoch invalidated negative cache.
// Used by the front, back and top level; depends on nothing.
package einc_pkg;

  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned HASH_SHIFT  = 16;
  localparam int unsigned HASH_W      = 32 - HASH_SHIFT;
  localparam int unsigned QUEUE_DEPTH = 8;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_QUERY      = 2'd0,
    OP_RECORD     = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_NOP        = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] address;
    logic [31:0] space_id;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } result_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic [31:0] space;
    logic [31:0] address;
  } entry_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_status_t;

endpackage

// File: src/epoch_invalidated_negative_cache.sv
// Top level of the epoch invalidated negative cache.
// Depends on einc_pkg, einc_front, einc_fifo and einc_back.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------
//   command  | in        | start high, busy low   | item_i   (item_t)
//   result   | out       | valid_o strobe, 1 cycle| result_o (result_t)
//
// One item per cycle is sustained outside a clearing pass; the single-port entry
// store, touched once per item by the back stage, sets that figure. An item's
// result passes through the four hash stages (the first loads on the edge that
// accepts it), the queue, the store read and the output register. After reset,
// and when an invalidate wraps the epoch, a clearing pass writes one slot per
// cycle, all SLOTS of them, while busy is high.
// Busy also rises when the queue credits run out; the receiver cannot stall.
module epoch_invalidated_negative_cache
  import einc_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    valid_o,
  output result_t result_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned QW = $bits(item_t) + SW;

  back_status_t  status;
  logic          push;
  item_t         f_item;
  logic [SW-1:0] f_idx;
  logic          q_valid;
  logic [QW-1:0] q_data;
  item_t         q_item;
  logic [SW-1:0] q_idx;

  // Front: accepts items and computes the slot of each one.
  einc_front #(
    .SLOTS(SLOTS),
    .SW   (SW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .status_i(status),
    .busy_o  (busy),
    .push_o  (push),
    .item_o  (f_item),
    .idx_o   (f_idx)
  );

  // The queue holds the items that leave the hash stages while the back clears.
  einc_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_item, f_idx}),
    .pop_i  (status.pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  assign q_item = q_data[QW-1:SW];
  assign q_idx  = q_data[SW-1:0];

  // Back: looks up or updates the store and keeps the current epoch.
  einc_back #(
    .SLOTS(SLOTS),
    .SW   (SW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_item_i (q_item),
    .q_idx_i  (q_idx),
    .status_o (status),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

// File: src/einc_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; depends on nothing.
module einc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/einc_fifo.sv
// Small register queue between the hash front and the cache back.
// Stand-alone; takes the assertion macros from assert_macros.svh.
`include "assert_macros.svh"

module einc_fifo #(
  parameter int unsigned WIDTH = 76,
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];

  `ASSERT_NEVER(fifo_overflow_a, clk_i, rst_ni, push_i && !pop_i && cnt_q == CW'(DEPTH), "queue overflow")
  `ASSERT_NEVER(fifo_underflow_a, clk_i, rst_ni, pop_i && cnt_q == '0, "pop from empty queue")

endmodule

// File: src/einc_front.sv
// Front of the negative cache: accepts items and hashes them to a slot.
// Depends on einc_pkg and the assertion macros.
`include "assert_macros.svh"

module einc_front
  import einc_pkg::*;
#(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned SW    = $clog2(SLOTS)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  item_t        item_i,
  input  back_status_t status_i,
  output logic         busy_o,
  output logic         push_o,
  output item_t        item_o,
  output logic [SW-1:0] idx_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  // Reciprocal for the slot modulo; the quotient estimate is low by at most one.
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(SLOTS);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [17:0] SLOTS18 = 18'(SLOTS);

  logic          accept;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [3:0]        vld_q;
  item_t             s1_item_q, s2_item_q, s3_item_q, s4_item_q;
  logic [31:0]       s1_m_q;
  logic [HASH_W-1:0] s2_x_q, s3_x_q;
  logic [HASH_W-1:0] s3_q_q;
  logic [SW-1:0]     s4_idx_q;

  logic [31:0]       m1;
  logic [31:0]       h2;
  logic [47:0]       prod3;
  logic [32:0]       qs4;
  logic [17:0]       r4, rc4;

  assign accept = start_i && !busy_o;
  assign busy_o = status_i.clearing || (cnt_q == CW'(QUEUE_DEPTH));

  // Credits cover the hash stages and the queue, so the stages never stall.
  always_comb begin
    cnt_d = cnt_q;
    if (accept && !status_i.pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (status_i.pop && !accept) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  assign m1    = item_i.space_id * HASH_MULT;
  assign h2    = ((s1_item_q.address >> 1) ^ s1_m_q) * HASH_MULT;
  assign prod3 = 48'(s2_x_q) * 48'(RECIP);
  assign qs4   = 33'(s3_q_q) * 33'(SLOTS);
  assign r4    = 18'(s3_x_q) - qs4[17:0];
  assign rc4   = (r4 >= SLOTS18) ? r4 - SLOTS18 : r4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= {vld_q[2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
    s1_m_q    <= m1;
    s2_item_q <= s1_item_q;
    s2_x_q    <= h2[31:HASH_SHIFT];
    s3_item_q <= s2_item_q;
    s3_x_q    <= s2_x_q;
    s3_q_q    <= prod3[47:32];
    s4_item_q <= s3_item_q;
    s4_idx_q  <= rc4[SW-1:0];
  end

  assign push_o = vld_q[3];
  assign item_o = s4_item_q;
  assign idx_o  = s4_idx_q;

  `ASSERT_NEVER(credit_range_a, clk_i, rst_ni, cnt_q > CW'(QUEUE_DEPTH), "credit count above queue depth")

endmodule

// File: src/einc_back.sv
// Back of the negative cache: the entry store, the epoch and the clearing pass.
// Depends on einc_pkg, einc_ram and the assertion macros.
`include "assert_macros.svh"

module einc_back
  import einc_pkg::*;
#(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned SW    = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  item_t         q_item_i,
  input  logic [SW-1:0] q_idx_i,
  output back_status_t  status_o,
  output logic          valid_o,
  output result_t       result_o
);

  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  logic          pop;
  logic          clear_q, clear_d;
  logic [SW-1:0] clr_cnt_q, clr_cnt_d;
  logic [31:0]   epoch_q, epoch_d;

  logic          ram_we;
  logic [SW-1:0] ram_addr;
  entry_t        ram_wdata, ram_rdata;

  logic          b_valid_q;
  op_e           b_op_q;
  logic [31:0]   b_addr_q, b_space_q, b_epoch_q;
  logic [SW-1:0] b_idx_q;

  logic          valid_q;
  result_t       res_q, res_d;

  assign pop = q_valid_i && !clear_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = q_idx_i;
    ram_wdata = '{epoch: epoch_q, space: q_item_i.space_id, address: q_item_i.address};
    epoch_d   = epoch_q;
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (clear_q) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
      if (clr_cnt_q == LAST) begin
        clear_d   = 1'b0;
        clr_cnt_d = '0;
      end else begin
        clr_cnt_d = clr_cnt_q + SW'(1);
      end
    end else if (pop) begin
      case (q_item_i.opcode)
        OP_RECORD: begin
          ram_we = 1'b1;
        end
        OP_INVALIDATE: begin
          if (epoch_q == '1) begin
            epoch_d   = 32'd1;
            clear_d   = 1'b1;
            clr_cnt_d = '0;
          end else begin
            epoch_d = epoch_q + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  einc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // The query compares against the epoch it was issued under.
  always_comb begin
    res_d.hit  = (b_op_q == OP_QUERY) && (ram_rdata.epoch == b_epoch_q) &&
                 (ram_rdata.address == b_addr_q) && (ram_rdata.space == b_space_q);
    res_d.slot = (b_op_q == OP_QUERY || b_op_q == OP_RECORD) ? SLOT_W'(b_idx_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
      epoch_q   <= 32'd1;
      b_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
      epoch_q   <= epoch_d;
      b_valid_q <= pop;
      valid_q   <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_op_q    <= q_item_i.opcode;
    b_addr_q  <= q_item_i.address;
    b_space_q <= q_item_i.space_id;
    b_idx_q   <= q_idx_i;
    b_epoch_q <= epoch_q;
    res_q     <= res_d;
  end

  assign status_o.clearing = clear_q;
  assign status_o.pop      = pop;
  assign valid_o           = valid_q;
  assign result_o          = res_q;

  `ASSERT_NEVER(epoch_nonzero_a, clk_i, rst_ni, epoch_q == '0, "current epoch is zero")
  `ASSERT_CLK(wrap_clear_a, clk_i, rst_ni, (pop && q_item_i.opcode == OP_INVALIDATE && epoch_q == '1) |=> (clear_q && epoch_q == 32'd1), "epoch wrap did not start a clearing pass")

endmodule
